// ===== rtl/cld_pkg.sv =====
// Shared types and constants for the console line discipline.
// No dependencies; every other file of the block except cld_ram refers to this package by scoped names.

package cld_pkg;

  // Input operation codes.
  localparam logic [1:0] OP_TX_READY = 2'd0;
  localparam logic [1:0] OP_RX       = 2'd1;
  localparam logic [1:0] OP_WRITE    = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // Control characters.
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Classified commands handed from the front end to the back end.
  typedef enum logic [1:0] {
    CMD_READY,
    CMD_RX,
    CMD_WRITE
  } cmd_e;

  typedef struct packed {
    cmd_e       kind;
    logic [7:0] data;
  } cmd_t;

endpackage

// ===== rtl/cld_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.

module cld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cld_front.sv =====
// Front end: accepts input requests and classifies them into commands.
// Depends on cld_pkg for op codes, control characters and the command type.

module cld_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    op_i,
  input  logic [7:0]    data_byte_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output cld_pkg::cmd_t push_cmd_o
);

  logic          valid_q, valid_d;
  cld_pkg::cmd_t cmd_q, cmd_d;
  logic          keep;
  cld_pkg::cmd_t cls;

  // Classify the incoming request; a received CR becomes LF here.
  always_comb begin
    keep     = 1'b1;
    cls.kind = cld_pkg::CMD_READY;
    cls.data = data_byte_i;
    case (op_i)
      cld_pkg::OP_TX_READY: begin
        cls.kind = cld_pkg::CMD_READY;
      end
      cld_pkg::OP_RX: begin
        cls.kind = cld_pkg::CMD_RX;
        if (data_byte_i == cld_pkg::CH_CR) begin
          cls.data = cld_pkg::CH_LF;
        end
      end
      cld_pkg::OP_WRITE: begin
        cls.kind = cld_pkg::CMD_WRITE;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // The holding register frees up when its command moves into the queue.
  assign in_ready_o = !valid_q || push_ready_i;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (push_ready_i) begin
      valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      valid_d = keep;
      cmd_d   = cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cmd_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cmd_q   <= cmd_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_cmd_o   = cmd_q;

endmodule

// ===== rtl/cld_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on cld_pkg for the command type.

module cld_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  cld_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output cld_pkg::cmd_t pop_cmd_o
);

  cld_pkg::cmd_t slot_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;
  logic          push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Storage slots carry no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/cld_back.sv =====
// Back end: carries out commands against the transmit FIFO and the line store,
// and drives the result register. Depends on cld_pkg and cld_ram.

module cld_back #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  cld_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    kind_o,
  output logic [7:0]    out_byte_o,
  output logic [5:0]    line_length_o,
  output logic          last_o
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_CR,
    ST_PUSH_BYTE,
    ST_START,
    ST_TX_READ,
    ST_LINE,
    ST_LINE_READ,
    ST_LINE_END
  } state_e;

  state_e        state_q, state_d;
  cld_pkg::cmd_t cmd_q, cmd_d;
  logic [AW-1:0] tx_head_q, tx_head_d;
  logic [CW-1:0] tx_count_q, tx_count_d;
  logic          tx_active_q, tx_active_d;
  logic [CW-1:0] line_count_q, line_count_d;
  logic [AW-1:0] line_idx_q, line_idx_d;
  logic          client_q, client_d;
  logic          out_valid_q, out_valid_d;
  logic [1:0]    kind_q, kind_d;
  logic [7:0]    byte_q, byte_d;
  logic [5:0]    len_q, len_d;
  logic          last_q, last_d;

  logic          tx_we, tx_re, ln_we, ln_re;
  logic [AW-1:0] tx_waddr, ln_raddr;
  logic [7:0]    tx_wdata, tx_rdata, ln_rdata;
  logic [CW:0]   tail_sum;
  logic [AW-1:0] tail, head_inc;
  logic          tx_full, line_full, is_lf, collect, out_free;

  // Tail position wraps at the buffer depth; the sum stays below twice the depth.
  assign tail_sum = (CW+1)'(tx_head_q) + (CW+1)'(tx_count_q);
  assign tail     = (tail_sum >= (CW+1)'(BUFFER_DEPTH))
                  ? AW'(tail_sum - (CW+1)'(BUFFER_DEPTH)) : AW'(tail_sum);
  assign head_inc = (tx_head_q == AW'(BUFFER_DEPTH - 1)) ? '0 : tx_head_q + 1'b1;

  assign tx_full   = (tx_count_q == CW'(BUFFER_DEPTH));
  assign line_full = (line_count_q == CW'(BUFFER_DEPTH));
  assign is_lf     = (cmd_q.data == cld_pkg::CH_LF);
  assign collect   = (cmd_q.kind == cld_pkg::CMD_RX) && client_q;
  assign out_free  = !out_valid_q || out_ready_i;

  // Sequencer: next state, store accesses and result register loads.
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    tx_head_d    = tx_head_q;
    tx_count_d   = tx_count_q;
    tx_active_d  = tx_active_q;
    line_count_d = line_count_q;
    line_idx_d   = line_idx_q;
    client_d     = cfg_we_i ? cfg_wdata_i : client_q;
    out_valid_d  = out_ready_i ? 1'b0 : out_valid_q;
    kind_d       = kind_q;
    byte_d       = byte_q;
    len_d        = len_q;
    last_d       = last_q;
    tx_we        = 1'b0;
    tx_waddr     = tail;
    tx_wdata     = cmd_q.data;
    tx_re        = 1'b0;
    ln_we        = 1'b0;
    ln_re        = 1'b0;
    ln_raddr     = line_idx_q;
    cmd_ready_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          case (cmd_i.kind)
            cld_pkg::CMD_READY: begin
              if (tx_active_q) begin
                if (!client_q || tx_count_q == '0) begin
                  tx_active_d = 1'b0;
                end else begin
                  tx_re      = 1'b1;
                  tx_head_d  = head_inc;
                  tx_count_d = tx_count_q - 1'b1;
                  state_d    = ST_TX_READ;
                end
              end
            end
            cld_pkg::CMD_RX, cld_pkg::CMD_WRITE: begin
              state_d = (cmd_i.data == cld_pkg::CH_LF) ? ST_PUSH_CR : ST_PUSH_BYTE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      // An LF is preceded by a CR in the transmit FIFO.
      ST_PUSH_CR: begin
        if (!tx_full) begin
          tx_we      = 1'b1;
          tx_wdata   = cld_pkg::CH_CR;
          tx_count_d = tx_count_q + 1'b1;
        end
        state_d = ST_PUSH_BYTE;
      end

      ST_PUSH_BYTE: begin
        if (!tx_full) begin
          tx_we      = 1'b1;
          tx_count_d = tx_count_q + 1'b1;
        end
        state_d = ST_START;
      end

      // Switch the transmitter on and send the head byte if it was off.
      ST_START: begin
        if (tx_count_q != '0 && !tx_active_q) begin
          tx_re       = 1'b1;
          tx_head_d   = head_inc;
          tx_count_d  = tx_count_q - 1'b1;
          tx_active_d = 1'b1;
          state_d     = ST_TX_READ;
        end else begin
          state_d = ST_LINE;
        end
      end

      ST_TX_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = cld_pkg::KIND_TX;
          byte_d      = tx_rdata;
          len_d       = '0;
          last_d      = (cmd_q.kind == cld_pkg::CMD_READY) || !(collect && is_lf);
          state_d     = (cmd_q.kind == cld_pkg::CMD_READY) ? ST_IDLE : ST_LINE;
        end
      end

      // With a client attached, collect a received byte, or start emitting the stored line on LF.
      ST_LINE: begin
        state_d = ST_IDLE;
        if (collect) begin
          if (!is_lf) begin
            if (!line_full) begin
              ln_we        = 1'b1;
              line_count_d = line_count_q + 1'b1;
            end
          end else if (line_count_q == '0) begin
            state_d = ST_LINE_END;
          end else begin
            ln_re      = 1'b1;
            ln_raddr   = '0;
            line_idx_d = '0;
            state_d    = ST_LINE_READ;
          end
        end
      end

      // Each line byte is emitted while the next one is read.
      ST_LINE_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = cld_pkg::KIND_LINE;
          byte_d      = ln_rdata;
          len_d       = '0;
          last_d      = 1'b0;
          if (CW'(line_idx_q) + 1'b1 < line_count_q) begin
            ln_re      = 1'b1;
            ln_raddr   = line_idx_q + 1'b1;
            line_idx_d = line_idx_q + 1'b1;
          end else begin
            state_d = ST_LINE_END;
          end
        end
      end

      ST_LINE_END: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          kind_d       = cld_pkg::KIND_END;
          byte_d       = '0;
          len_d        = 6'(line_count_q);
          last_d       = 1'b1;
          line_count_d = '0;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, counters, configuration and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cmd_q        <= '0;
      tx_head_q    <= '0;
      tx_count_q   <= '0;
      tx_active_q  <= 1'b0;
      line_count_q <= '0;
      line_idx_q   <= '0;
      client_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      kind_q       <= '0;
      byte_q       <= '0;
      len_q        <= '0;
      last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      tx_head_q    <= tx_head_d;
      tx_count_q   <= tx_count_d;
      tx_active_q  <= tx_active_d;
      line_count_q <= line_count_d;
      line_idx_q   <= line_idx_d;
      client_q     <= client_d;
      out_valid_q  <= out_valid_d;
      kind_q       <= kind_d;
      byte_q       <= byte_d;
      len_q        <= len_d;
      last_q       <= last_d;
    end
  end

  // Transmit FIFO storage.
  cld_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_waddr),
    .wdata_i (tx_wdata),
    .re_i    (tx_re),
    .raddr_i (tx_head_q),
    .rdata_o (tx_rdata)
  );

  // Line store.
  cld_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ln_we),
    .waddr_i (line_count_q[AW-1:0]),
    .wdata_i (cmd_q.data),
    .re_i    (ln_re),
    .raddr_i (ln_raddr),
    .rdata_o (ln_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign out_byte_o    = byte_q;
  assign line_length_o = len_q;
  assign last_o        = last_q;

`ifndef SYNTH
  a_tx_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_count_q <= CW'(BUFFER_DEPTH))
    else $error("transmit FIFO count exceeds its depth");

  a_line_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_count_q <= CW'(BUFFER_DEPTH))
    else $error("line store count exceeds its depth");

  a_tx_read_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_TX_READ |-> tx_active_q)
    else $error("transmit byte read while the transmitter is off");

  a_line_read_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LINE_READ |-> CW'(line_idx_q) < line_count_q)
    else $error("line read index beyond the stored line");
`endif

endmodule

// ===== rtl/console_line_discipline.sv =====
// Top level of the console line discipline: front end, command queue, back end.
// Depends on cld_pkg, cld_front, cld_queue, cld_back and cld_ram.
//
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i/in_ready_o   op_i, data_byte_i
// result    out        out_valid_o/out_ready_i kind_o, out_byte_o, line_length_o, last_o
// config    in         cfg_we_i                cfg_wdata_i (client_attached)
//
// The back-end sequencer takes one command at a time. A transmitter-ready request
// may send a byte from the transmit FIFO; a written or received byte passes the
// push, start and line states, with a CR pushed ahead of an LF; a received LF with a client
// attached then reads an N-byte line out through the one read port of the line store.
// Reset is asynchronous and active low; the stores need no clearing pass.
// The two-entry command queue lets requests come in while results are stalled.

module console_line_discipline #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic [7:0] data_byte_i,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic [5:0] line_length_o,
  output logic       last_o
);

  logic          front_valid, front_ready;
  cld_pkg::cmd_t front_cmd;
  logic          back_valid, back_ready;
  cld_pkg::cmd_t back_cmd;

  cld_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .data_byte_i  (data_byte_i),
    .push_valid_o (front_valid),
    .push_ready_i (front_ready),
    .push_cmd_o   (front_cmd)
  );

  cld_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_cmd_o    (back_cmd)
  );

  cld_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_valid_i   (back_valid),
    .cmd_ready_o   (back_ready),
    .cmd_i         (back_cmd),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .out_byte_o    (out_byte_o),
    .line_length_o (line_length_o),
    .last_o        (last_o)
  );

endmodule
